[rtl/rrfsm_pkg.sv]
// Shared types and constants for the initial ranging request retry controller.
// No dependencies; imported by rrfsm_regs, rrfsm_core and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rrfsm_pkg;

	localparam int IdW    = 16;
	localparam int WinW   = 14;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_RSP   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_SEND    = 2'd0,
		KIND_SUCCESS = 2'd1,
		KIND_FAIL    = 2'd2,
		KIND_BUSY    = 2'd3
	} kind_t;

	localparam logic [CfgIdxW-1:0] REG_OWN_STATION   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT       = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_BACKOFF_MIN   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BACKOFF_MAX   = 3'd4;

	localparam logic [IdW-1:0] TXN_ID_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] own_station_id;
		logic [7:0]  response_timeout_frames;
		logic [3:0]  max_retries;
		logic [9:0]  backoff_window_min;
		logic [13:0] backoff_window_max;
	} cfg_t;

	typedef struct packed {
		logic [1:0]     op;
		logic [IdW-1:0] base_station;
		logic [IdW-1:0] rsp_subscriber_station;
		logic [IdW-1:0] rsp_transaction_id;
		logic [IdW-1:0] rsp_basic_cid;
		logic [IdW-1:0] rsp_primary_cid;
	} item_t;

	typedef struct packed {
		kind_t           kind;
		logic [IdW-1:0]  req_transaction_id;
		logic [IdW-1:0]  req_base_station;
		logic [WinW-1:0] backoff_window;
		logic [IdW-1:0]  basic_cid;
		logic [IdW-1:0]  primary_cid;
	} result_t;

	typedef struct packed {
		logic busy;
		logic armed;
	} status_t;

endpackage
`default_nettype wire

[rtl/rrfsm_regs.sv]
// Configuration register file for the ranging retry controller.
// Depends on rrfsm_pkg (cfg_t, register index constants).
`timescale 1ns / 1ps
`default_nettype none
module rrfsm_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rrfsm_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [rrfsm_pkg::CfgDataW-1:0]  cfg_data,
	output rrfsm_pkg::cfg_t                      cfg
);
	import rrfsm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_station_id          <= 16'd1;
			cfg_q.response_timeout_frames <= 8'd3;
			cfg_q.max_retries             <= 4'd3;
			cfg_q.backoff_window_min      <= 10'd2;
			cfg_q.backoff_window_max      <= 14'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_STATION: cfg_q.own_station_id          <= cfg_data;
				REG_TIMEOUT:     cfg_q.response_timeout_frames <= cfg_data[7:0];
				REG_MAX_RETRIES: cfg_q.max_retries             <= cfg_data[3:0];
				REG_BACKOFF_MIN: cfg_q.backoff_window_min      <= cfg_data[9:0];
				REG_BACKOFF_MAX: cfg_q.backoff_window_max      <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/rrfsm_core.sv]
// Ranging state (transaction ids, frame timer, retry count) and per-request decode.
// Depends on rrfsm_pkg; one request is processed per cycle when fire is high.
`timescale 1ns / 1ps
`default_nettype none
module rrfsm_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  rrfsm_pkg::item_t item,
	input  rrfsm_pkg::cfg_t  cfg,
	output logic             res_valid,
	output rrfsm_pkg::result_t res,
	output rrfsm_pkg::status_t status
);
	import rrfsm_pkg::*;

	logic                busy_q, busy_d;
	logic [IdW-1:0]      last_txn_q, last_txn_d;
	logic [IdW-1:0]      active_txn_q, active_txn_d;
	logic signed [8:0]   frames_q, frames_d;
	logic signed [5:0]   retries_q, retries_d;
	logic [IdW-1:0]      target_q, target_d;

	logic signed [5:0]   r_start, r_tick, r_sel;
	logic [IdW-1:0]      txn_next;
	logic signed [6:0]   attempt;
	logic [14:0]         prod;
	logic [WinW-1:0]     window;
	logic [8:0]          timeout_ext;

	// window = min * attempt, capped at max; zero attempt gives 0, negative gives max (0 if min is 0)
	always_comb begin
		r_start = (retries_q < 0) ? (6'sd1 + $signed({2'b00, cfg.max_retries})) - 6'sd1
		                          : retries_q - 6'sd1;
		r_tick  = retries_q - 6'sd1;
		r_sel   = (item.op == OP_START) ? r_start : r_tick;
		attempt = $signed({3'b000, cfg.max_retries}) - 7'(r_sel) + 7'sd1;
		prod    = 15'(cfg.backoff_window_min) * 15'(attempt[4:0]);
		if (attempt <= 0) begin
			window = (attempt == 0 || cfg.backoff_window_min == '0)
			         ? '0 : cfg.backoff_window_max;
		end else if (prod > {1'b0, cfg.backoff_window_max}) begin
			window = cfg.backoff_window_max;
		end else begin
			window = prod[WinW-1:0];
		end
		txn_next    = (last_txn_q == TXN_ID_MAX) ? 16'd1 : last_txn_q + 16'd1;
		timeout_ext = {1'b0, cfg.response_timeout_frames};
	end

	always_comb begin
		busy_d       = busy_q;
		last_txn_d   = last_txn_q;
		active_txn_d = active_txn_q;
		frames_d     = frames_q;
		retries_d    = retries_q;
		target_d     = target_q;
		res_valid    = 1'b0;
		res          = '0;
		if (fire) begin
			unique case (item.op)
				OP_START: begin
					res_valid = 1'b1;
					if (busy_q) begin
						res.kind = KIND_BUSY;
					end else begin
						busy_d       = 1'b1;
						target_d     = item.base_station;
						last_txn_d   = txn_next;
						active_txn_d = txn_next;
						retries_d    = r_start;
						frames_d     = $signed(timeout_ext);
						res.kind               = KIND_SEND;
						res.req_transaction_id = txn_next;
						res.req_base_station   = item.base_station;
						res.backoff_window     = window;
					end
				end
				OP_TICK: begin
					if (frames_q == 0) begin
						res_valid = 1'b1;
						if (retries_q > 0) begin
							retries_d = r_tick;
							frames_d  = (timeout_ext == '0) ? 9'sd0
							            : $signed(timeout_ext - 9'd1);
							res.kind               = KIND_SEND;
							res.req_transaction_id = active_txn_q;
							res.req_base_station   = target_q;
							res.backoff_window     = window;
						end else begin
							retries_d = -6'sd1;
							frames_d  = -9'sd1;
							busy_d    = 1'b0;
							res.kind  = KIND_FAIL;
						end
					end else if (frames_q > 0) begin
						frames_d = frames_q - 9'sd1;
					end
				end
				OP_RSP: begin
					if (item.rsp_subscriber_station == cfg.own_station_id && frames_q > 0
					    && item.rsp_transaction_id == active_txn_q) begin
						frames_d    = -9'sd1;
						retries_d   = -6'sd1;
						busy_d      = 1'b0;
						res_valid   = 1'b1;
						res.kind    = KIND_SUCCESS;
						res.basic_cid   = item.rsp_basic_cid;
						res.primary_cid = item.rsp_primary_cid;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			last_txn_q   <= '0;
			active_txn_q <= '0;
			frames_q     <= -9'sd1;
			retries_q    <= -6'sd1;
			target_q     <= '0;
		end else begin
			busy_q       <= busy_d;
			last_txn_q   <= last_txn_d;
			active_txn_q <= active_txn_d;
			frames_q     <= frames_d;
			retries_q    <= retries_d;
			target_q     <= target_d;
		end
	end

	assign status.busy  = busy_q;
	assign status.armed = (frames_q >= 0);

endmodule
`default_nettype wire

[rtl/ranging_request_retry_fsm_top.sv]
// Top level of the subscriber initial ranging controller: input register,
// result register, config registers. Depends on rrfsm_pkg, rrfsm_regs, rrfsm_core.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  in       | in_valid / in_stall       | op, base_station, rsp_* fields
//  out      | out_valid / out_stall     | kind, req_*, backoff_window, *_cid
//  cfg      | cfg_we (no back-pressure) | cfg_index, cfg_data
//
// One request per cycle while out_stall does not hold the result register. A request
// taken into the input register is decoded when it fires, and its result is written
// into the result register, from which it is shown on the out channel.
// Ticks that change only the timer and rejected responses give no result.
// Reset is asynchronous: timer disarmed, no attempt, transaction id 0.
// out_stall holds the result register; a new request is still taken into an empty
// input register, which then waits until the result slot frees.
`timescale 1ns / 1ps
`default_nettype none
module ranging_request_retry_fsm_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     op,
	input  wire logic [15:0]                    base_station,
	input  wire logic [15:0]                    rsp_subscriber_station,
	input  wire logic [15:0]                    rsp_transaction_id,
	input  wire logic [15:0]                    rsp_basic_cid,
	input  wire logic [15:0]                    rsp_primary_cid,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          kind,
	output logic [15:0]                         req_transaction_id,
	output logic [15:0]                         req_base_station,
	output logic [13:0]                         backoff_window,
	output logic [15:0]                         basic_cid,
	output logic [15:0]                         primary_cid,
	input  wire logic                           cfg_we,
	input  wire logic [rrfsm_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [rrfsm_pkg::CfgDataW-1:0] cfg_data
);
	import rrfsm_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res, res_q;
	logic    res_valid;
	logic    out_valid_q;
	logic    fire;
	logic    in_take;
	status_t status;

	rrfsm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	rrfsm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op                     <= op;
			item_s1.base_station           <= base_station;
			item_s1.rsp_subscriber_station <= rsp_subscriber_station;
			item_s1.rsp_transaction_id     <= rsp_transaction_id;
			item_s1.rsp_basic_cid          <= rsp_basic_cid;
			item_s1.rsp_primary_cid        <= rsp_primary_cid;
		end
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign kind               = res_q.kind;
	assign req_transaction_id = res_q.req_transaction_id;
	assign req_base_station   = res_q.req_base_station;
	assign backoff_window     = res_q.backoff_window;
	assign basic_cid          = res_q.basic_cid;
	assign primary_cid        = res_q.primary_cid;

	a_idle_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy |-> !status.armed)
		else $error("timer armed while no ranging attempt is active");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !fire)
		else $error("request processed while the result register is held");

	a_busy_reject: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.op == OP_START && status.busy |-> res_valid && res.kind == KIND_BUSY)
		else $error("start during an active attempt was not refused");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && (res.kind == KIND_SUCCESS || res.kind == KIND_FAIL)
		|=> !status.busy && !status.armed)
		else $error("attempt still active after success or failure");

endmodule
`default_nettype wire
